>>> rtl/tspa_pkg.sv
`timescale 1ns / 1ps
// tspa_pkg: shared types and constants for the two-size page allocator
// no dependencies

package tspa_pkg;

   // page geometry
   localparam int unsigned SPH_BITS    = 9;           // small pages per huge page, log2
   localparam logic [8:0]  SPH_LAST    = 9'd511;      // last small page inside a huge page
   localparam int unsigned SMALL_SHIFT = 12;          // 0x1000 bytes
   localparam int unsigned HUGE_SHIFT  = 21;          // 0x200000 bytes
   localparam int unsigned ADDR_W      = 27;

   // operation codes
   localparam logic [1:0] OP_RESERVE = 2'd0;
   localparam logic [1:0] OP_BUILD   = 2'd1;
   localparam logic [1:0] OP_ALLOC   = 2'd2;
   localparam logic [1:0] OP_FREE    = 2'd3;

   // page kinds
   localparam logic [1:0] KIND_SMALL = 2'd0;
   localparam logic [1:0] KIND_HUGE  = 2'd1;

   // result status codes
   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_EMPTY    = 3'd1;
   localparam logic [2:0] STAT_BAD_SIZE = 3'd2;
   localparam logic [2:0] STAT_REJECT   = 3'd3;
   localparam logic [2:0] STAT_RANGE    = 3'd4;
   localparam logic [2:0] STAT_FULL     = 3'd5;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_RSV,
      S_B1_RD,
      S_B1_EV,
      S_B1_SRD,
      S_B1_SEV,
      S_B2_RD,
      S_B2_EV,
      S_AH_POP,
      S_AH_WAIT,
      S_AH_SRD,
      S_AH_SEV,
      S_AH_MARK,
      S_AS_POP,
      S_AS_WAIT,
      S_AS_EV,
      S_FH_RD,
      S_FH_EV,
      S_FH_CLR,
      S_FH_PH,
      S_FH_PS,
      S_FS_RD,
      S_FS_EV,
      S_DONE
   } state_type;

endpackage

>>> rtl/two_size_page_allocator_unit.sv
`timescale 1ns / 1ps
// two_size_page_allocator_unit: small/huge page allocator with used bitmaps and free stacks
// depends on tspa_pkg
//
// reserve walks the range page by page; allocate pops its stack until a usable entry turns
//   up, and huge allocate then marks all 512 small bits; free checks, clears and pushes (huge
//   free: the huge page, then its small pages); build walks huge pages, then small pages; each
//   memory has a write port and a registered read port, so a lookup is a read then an evaluate state
// throughput: one item at a time, the next transfer is taken when the result is registered
// reset: synchronous; afterwards a clearing pass zeroes both bitmaps before the first request is taken

module two_size_page_allocator_unit #(
   parameter int unsigned HUGE_PAGES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [1:0]  req_page_kind,
   input  logic [14:0] req_first_page,
   input  logic [15:0] req_range_length,
   input  logic [26:0] req_free_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [26:0] rsp_page_address,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   // index widths derived from the huge page count
   localparam int unsigned HW        = (HUGE_PAGES > 1) ? $clog2(HUGE_PAGES) : 1;
   localparam int unsigned SW        = HW + tspa_pkg::SPH_BITS;
   localparam int unsigned HTW       = HW + 1;
   localparam int unsigned STW       = SW + 1;
   localparam int unsigned SMALL_CAP = HUGE_PAGES * 512;
   localparam int unsigned TW        = ($clog2(SMALL_CAP + 1) > 16) ? $clog2(SMALL_CAP + 1) : 16;
   localparam int unsigned CW        = TW + 1;
   localparam int unsigned AW        = tspa_pkg::ADDR_W;

   // sequencer and working registers
   tspa_pkg::state_type state_ff, state_in;
   logic [TW-1:0]  total_ff;
   logic [1:0]     kind_ff, kind_in;
   logic [14:0]    first_ff, first_in;
   logic [15:0]    len_ff, len_in;
   logic [26:0]    faddr_ff, faddr_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [8:0]     j_ff, j_in;
   logic [SW-1:0]  cur_ff, cur_in;
   logic [HW-1:0]  hcur_ff, hcur_in;
   logic [2:0]     stat_ff, stat_in;
   logic [AW-1:0]  res_ff, res_in;
   logic [HTW-1:0] htop_ff, htop_in;
   logic [STW-1:0] stop_ff, stop_in;

   // result register
   logic           rsp_valid_ff, rsp_valid_in;
   logic [2:0]     rsp_status_ff, rsp_status_in;
   logic [AW-1:0]  rsp_addr_ff, rsp_addr_in;

   // memories: small bitmap, huge bitmap, huge stack, small stack
   logic           smap_mem [SMALL_CAP];
   logic           hmap_mem [HUGE_PAGES];
   logic [HW-1:0]  hstk_mem [HUGE_PAGES];
   logic [SW-1:0]  sstk_mem [SMALL_CAP];

   logic           smap_we, smap_wdata, smap_rd_ff;
   logic [SW-1:0]  smap_waddr, smap_raddr;
   logic           hmap_we, hmap_wdata, hmap_rd_ff;
   logic [HW-1:0]  hmap_waddr, hmap_raddr;
   logic           hstk_we;
   logic [HW-1:0]  hstk_waddr, hstk_wdata, hstk_raddr, hstk_rd_ff;
   logic           sstk_we;
   logic [SW-1:0]  sstk_waddr, sstk_wdata, sstk_raddr, sstk_rd_ff;

   // push requests, resolved against the stack tops after the main case
   logic           hpush;
   logic [HW-1:0]  hpush_idx;
   logic           spush;
   logic [SW-1:0]  spush_idx;

   // derived values
   logic [TW-10:0] nh;
   logic [CW-1:0]  nh_ext, total_ext, cnt_inc;
   logic [CW:0]    rsv_p, rsv_limit;
   logic           j_last;
   logic [5:0]     fh_idx;
   logic [14:0]    fs_idx;
   logic [SW-1:0]  fs_small;
   logic           fh_oor, fs_oor;
   logic [HTW-1:0] htop_dec;
   logic [STW-1:0] stop_dec;
   logic           out_free;

   assign nh        = total_ff[TW-1:tspa_pkg::SPH_BITS];
   assign nh_ext    = CW'(nh);
   assign total_ext = CW'(total_ff);
   assign cnt_inc   = cnt_ff + CW'(1);
   assign rsv_p     = (CW+1)'(first_ff) + (CW+1)'(cnt_ff);
   assign rsv_limit = (kind_ff == tspa_pkg::KIND_SMALL) ? (CW+1)'(total_ff) : (CW+1)'(nh);
   assign j_last    = (j_ff == tspa_pkg::SPH_LAST);
   assign fh_idx    = faddr_ff[26:tspa_pkg::HUGE_SHIFT];
   assign fs_idx    = faddr_ff[26:tspa_pkg::SMALL_SHIFT];
   assign fs_small  = SW'(fs_idx);
   assign fh_oor    = (CW'(fh_idx) >= nh_ext);
   assign fs_oor    = (CW'(fs_idx) >= total_ext);
   assign htop_dec  = htop_ff - HTW'(1);
   assign stop_dec  = stop_ff - STW'(1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // a new transfer is taken only in idle
   assign req_stall        = (state_ff != tspa_pkg::S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_page_address = rsp_addr_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tspa_pkg::S_CLEAR: begin
            if (cnt_ff == CW'(SMALL_CAP - 1)) state_in = tspa_pkg::S_IDLE;
         end
         tspa_pkg::S_IDLE: begin
            if (req_valid) begin
               if (req_operation == tspa_pkg::OP_BUILD) begin
                  state_in = tspa_pkg::S_B1_RD;
               end else if (req_page_kind != tspa_pkg::KIND_SMALL &&
                            req_page_kind != tspa_pkg::KIND_HUGE) begin
                  state_in = tspa_pkg::S_DONE;
               end else if (req_operation == tspa_pkg::OP_RESERVE) begin
                  state_in = tspa_pkg::S_RSV;
               end else if (req_operation == tspa_pkg::OP_ALLOC) begin
                  state_in = (req_page_kind == tspa_pkg::KIND_HUGE) ?
                             tspa_pkg::S_AH_POP : tspa_pkg::S_AS_POP;
               end else begin
                  state_in = (req_page_kind == tspa_pkg::KIND_HUGE) ?
                             tspa_pkg::S_FH_RD : tspa_pkg::S_FS_RD;
               end
            end
         end
         tspa_pkg::S_RSV: begin
            if (cnt_ff == CW'(len_ff)) state_in = tspa_pkg::S_DONE;
         end
         tspa_pkg::S_B1_RD: begin
            state_in = (cnt_ff >= nh_ext) ? tspa_pkg::S_B2_RD : tspa_pkg::S_B1_EV;
         end
         tspa_pkg::S_B1_EV: begin
            state_in = hmap_rd_ff ? tspa_pkg::S_B1_RD : tspa_pkg::S_B1_SRD;
         end
         tspa_pkg::S_B1_SRD: state_in = tspa_pkg::S_B1_SEV;
         tspa_pkg::S_B1_SEV: begin
            state_in = (smap_rd_ff || j_last) ? tspa_pkg::S_B1_RD : tspa_pkg::S_B1_SRD;
         end
         tspa_pkg::S_B2_RD: begin
            state_in = (cnt_ff >= total_ext) ? tspa_pkg::S_DONE : tspa_pkg::S_B2_EV;
         end
         tspa_pkg::S_B2_EV: state_in = tspa_pkg::S_B2_RD;
         tspa_pkg::S_AH_POP: begin
            state_in = (htop_ff == '0) ? tspa_pkg::S_DONE : tspa_pkg::S_AH_WAIT;
         end
         tspa_pkg::S_AH_WAIT: state_in = tspa_pkg::S_AH_SRD;
         tspa_pkg::S_AH_SRD:  state_in = tspa_pkg::S_AH_SEV;
         tspa_pkg::S_AH_SEV: begin
            if (smap_rd_ff)  state_in = tspa_pkg::S_AH_POP;
            else if (j_last) state_in = tspa_pkg::S_AH_MARK;
            else             state_in = tspa_pkg::S_AH_SRD;
         end
         tspa_pkg::S_AH_MARK: begin
            if (j_last) state_in = tspa_pkg::S_DONE;
         end
         tspa_pkg::S_AS_POP: begin
            state_in = (stop_ff == '0) ? tspa_pkg::S_DONE : tspa_pkg::S_AS_WAIT;
         end
         tspa_pkg::S_AS_WAIT: state_in = tspa_pkg::S_AS_EV;
         tspa_pkg::S_AS_EV: begin
            state_in = hmap_rd_ff ? tspa_pkg::S_AS_POP : tspa_pkg::S_DONE;
         end
         tspa_pkg::S_FH_RD: begin
            state_in = fh_oor ? tspa_pkg::S_DONE : tspa_pkg::S_FH_EV;
         end
         tspa_pkg::S_FH_EV: begin
            state_in = hmap_rd_ff ? tspa_pkg::S_FH_CLR : tspa_pkg::S_DONE;
         end
         tspa_pkg::S_FH_CLR: begin
            if (j_last) state_in = tspa_pkg::S_FH_PH;
         end
         tspa_pkg::S_FH_PH: state_in = tspa_pkg::S_FH_PS;
         tspa_pkg::S_FH_PS: begin
            if (j_last) state_in = tspa_pkg::S_DONE;
         end
         tspa_pkg::S_FS_RD: begin
            state_in = fs_oor ? tspa_pkg::S_DONE : tspa_pkg::S_FS_EV;
         end
         tspa_pkg::S_FS_EV: state_in = tspa_pkg::S_DONE;
         tspa_pkg::S_DONE: begin
            if (out_free) state_in = tspa_pkg::S_IDLE;
         end
         default: state_in = tspa_pkg::S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      kind_in       = kind_ff;
      first_in      = first_ff;
      len_in        = len_ff;
      faddr_in      = faddr_ff;
      cnt_in        = cnt_ff;
      j_in          = j_ff;
      cur_in        = cur_ff;
      hcur_in       = hcur_ff;
      stat_in       = stat_ff;
      res_in        = res_ff;
      htop_in       = htop_ff;
      stop_in       = stop_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      smap_we       = 1'b0;
      smap_waddr    = '0;
      smap_wdata    = 1'b0;
      smap_raddr    = '0;
      hmap_we       = 1'b0;
      hmap_waddr    = '0;
      hmap_wdata    = 1'b0;
      hmap_raddr    = '0;
      hstk_we       = 1'b0;
      hstk_waddr    = '0;
      hstk_wdata    = '0;
      hstk_raddr    = '0;
      sstk_we       = 1'b0;
      sstk_waddr    = '0;
      sstk_wdata    = '0;
      sstk_raddr    = '0;
      hpush         = 1'b0;
      hpush_idx     = '0;
      spush         = 1'b0;
      spush_idx     = '0;

      case (state_ff)
         // zero both bitmaps, one page a cycle
         tspa_pkg::S_CLEAR: begin
            smap_we    = 1'b1;
            smap_waddr = cnt_ff[SW-1:0];
            if (cnt_ff < CW'(HUGE_PAGES)) begin
               hmap_we    = 1'b1;
               hmap_waddr = cnt_ff[HW-1:0];
            end
            cnt_in = cnt_inc;
         end
         tspa_pkg::S_IDLE: begin
            if (req_valid) begin
               kind_in  = req_page_kind;
               first_in = req_first_page;
               len_in   = req_range_length;
               faddr_in = req_free_address;
               cnt_in   = '0;
               j_in     = '0;
               res_in   = '0;
               stat_in  = tspa_pkg::STAT_OK;
               if (req_operation != tspa_pkg::OP_BUILD &&
                   req_page_kind != tspa_pkg::KIND_SMALL &&
                   req_page_kind != tspa_pkg::KIND_HUGE) begin
                  stat_in = tspa_pkg::STAT_BAD_SIZE;
               end
            end
         end
         // reserve: one page of the range per cycle, out-of-range pages skipped
         tspa_pkg::S_RSV: begin
            if (cnt_ff != CW'(len_ff)) begin
               if (rsv_p >= rsv_limit) begin
                  stat_in = tspa_pkg::STAT_RANGE;
               end else if (kind_ff == tspa_pkg::KIND_SMALL) begin
                  smap_we    = 1'b1;
                  smap_waddr = rsv_p[SW-1:0];
                  smap_wdata = 1'b1;
               end else begin
                  hmap_we    = 1'b1;
                  hmap_waddr = rsv_p[HW-1:0];
                  hmap_wdata = 1'b1;
               end
               cnt_in = cnt_inc;
            end
         end
         // build pass one: huge pages
         tspa_pkg::S_B1_RD: begin
            if (cnt_ff >= nh_ext) cnt_in = '0;
            else                  hmap_raddr = cnt_ff[HW-1:0];
         end
         tspa_pkg::S_B1_EV: begin
            if (hmap_rd_ff) cnt_in = cnt_inc;
            else            j_in   = '0;
         end
         tspa_pkg::S_B1_SRD: begin
            smap_raddr = {cnt_ff[HW-1:0], j_ff};
         end
         tspa_pkg::S_B1_SEV: begin
            if (smap_rd_ff) begin
               // mixed huge page becomes used
               hmap_we    = 1'b1;
               hmap_waddr = cnt_ff[HW-1:0];
               hmap_wdata = 1'b1;
               cnt_in     = cnt_inc;
            end else if (j_last) begin
               hpush     = 1'b1;
               hpush_idx = cnt_ff[HW-1:0];
               cnt_in    = cnt_inc;
            end else begin
               j_in = j_ff + 9'd1;
            end
         end
         // build pass two: small pages
         tspa_pkg::S_B2_RD: begin
            smap_raddr = cnt_ff[SW-1:0];
            hmap_raddr = cnt_ff[SW-1:tspa_pkg::SPH_BITS];
         end
         tspa_pkg::S_B2_EV: begin
            if (!smap_rd_ff) begin
               if (hmap_rd_ff) begin
                  // shadowed by a used huge page
                  smap_we    = 1'b1;
                  smap_waddr = cnt_ff[SW-1:0];
                  smap_wdata = 1'b1;
               end else begin
                  spush     = 1'b1;
                  spush_idx = cnt_ff[SW-1:0];
               end
            end
            cnt_in = cnt_inc;
         end
         // huge allocate: pop, check all small bits, then mark
         tspa_pkg::S_AH_POP: begin
            if (htop_ff != '0) begin
               htop_in    = htop_dec;
               hstk_raddr = htop_dec[HW-1:0];
            end else begin
               stat_in = tspa_pkg::STAT_EMPTY;
            end
         end
         tspa_pkg::S_AH_WAIT: begin
            hcur_in = hstk_rd_ff;
            j_in    = '0;
         end
         tspa_pkg::S_AH_SRD: begin
            smap_raddr = {hcur_ff, j_ff};
         end
         tspa_pkg::S_AH_SEV: begin
            if (!smap_rd_ff) begin
               j_in = j_ff + 9'd1;
               if (j_last) begin
                  hmap_we    = 1'b1;
                  hmap_waddr = hcur_ff;
                  hmap_wdata = 1'b1;
               end
            end
         end
         tspa_pkg::S_AH_MARK: begin
            smap_we    = 1'b1;
            smap_waddr = {hcur_ff, j_ff};
            smap_wdata = 1'b1;
            j_in       = j_ff + 9'd1;
            if (j_last) res_in = AW'({hcur_ff, {tspa_pkg::HUGE_SHIFT{1'b0}}});
         end
         // small allocate: pop, skip entries under a used huge page
         tspa_pkg::S_AS_POP: begin
            if (stop_ff != '0) begin
               stop_in    = stop_dec;
               sstk_raddr = stop_dec[SW-1:0];
            end else begin
               stat_in = tspa_pkg::STAT_EMPTY;
            end
         end
         tspa_pkg::S_AS_WAIT: begin
            cur_in     = sstk_rd_ff;
            hmap_raddr = sstk_rd_ff[SW-1:tspa_pkg::SPH_BITS];
         end
         tspa_pkg::S_AS_EV: begin
            if (!hmap_rd_ff) begin
               smap_we    = 1'b1;
               smap_waddr = cur_ff;
               smap_wdata = 1'b1;
               res_in     = AW'({cur_ff, {tspa_pkg::SMALL_SHIFT{1'b0}}});
            end
         end
         // huge free: check, clear bits, push huge page then its small pages
         tspa_pkg::S_FH_RD: begin
            if (fh_oor) begin
               stat_in = tspa_pkg::STAT_RANGE;
            end else begin
               hmap_raddr = HW'(fh_idx);
               hcur_in    = HW'(fh_idx);
            end
         end
         tspa_pkg::S_FH_EV: begin
            if (!hmap_rd_ff) begin
               stat_in = tspa_pkg::STAT_REJECT;
            end else begin
               hmap_we    = 1'b1;
               hmap_waddr = hcur_ff;
               hmap_wdata = 1'b0;
               j_in       = '0;
            end
         end
         tspa_pkg::S_FH_CLR: begin
            smap_we    = 1'b1;
            smap_waddr = {hcur_ff, j_ff};
            smap_wdata = 1'b0;
            j_in       = j_ff + 9'd1;
         end
         tspa_pkg::S_FH_PH: begin
            hpush     = 1'b1;
            hpush_idx = hcur_ff;
            j_in      = '0;
         end
         tspa_pkg::S_FH_PS: begin
            spush     = 1'b1;
            spush_idx = {hcur_ff, j_ff};
            j_in      = j_ff + 9'd1;
         end
         // small free
         tspa_pkg::S_FS_RD: begin
            if (fs_oor) begin
               stat_in = tspa_pkg::STAT_RANGE;
            end else begin
               smap_raddr = fs_small;
               hmap_raddr = fs_small[SW-1:tspa_pkg::SPH_BITS];
               cur_in     = fs_small;
            end
         end
         tspa_pkg::S_FS_EV: begin
            if (!smap_rd_ff || hmap_rd_ff) begin
               stat_in = tspa_pkg::STAT_REJECT;
            end else begin
               smap_we    = 1'b1;
               smap_waddr = cur_ff;
               smap_wdata = 1'b0;
               spush      = 1'b1;
               spush_idx  = cur_ff;
            end
         end
         // hand the result to the output register
         tspa_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_addr_in   = (stat_ff == tspa_pkg::STAT_OK) ? res_ff : '0;
            end
         end
         default: begin
         end
      endcase

      // stack pushes, dropped and flagged when full
      if (hpush) begin
         if (htop_ff >= HTW'(HUGE_PAGES)) begin
            stat_in = tspa_pkg::STAT_FULL;
         end else begin
            hstk_we    = 1'b1;
            hstk_waddr = htop_ff[HW-1:0];
            hstk_wdata = hpush_idx;
            htop_in    = htop_ff + HTW'(1);
         end
      end
      if (spush) begin
         if (stop_ff >= STW'(SMALL_CAP)) begin
            stat_in = tspa_pkg::STAT_FULL;
         end else begin
            sstk_we    = 1'b1;
            sstk_waddr = stop_ff[SW-1:0];
            sstk_wdata = spush_idx;
            stop_in    = stop_ff + STW'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tspa_pkg::S_CLEAR;
         cnt_ff       <= '0;
         htop_ff      <= '0;
         stop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= TW'(SMALL_CAP);
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         htop_ff      <= htop_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
         // size register saturates at the full page count
         if (csr_write_enable) begin
            if (32'(csr_write_data) > SMALL_CAP) total_ff <= TW'(SMALL_CAP);
            else                                 total_ff <= TW'(csr_write_data);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      first_ff      <= first_in;
      len_ff        <= len_in;
      faddr_ff      <= faddr_in;
      j_ff          <= j_in;
      cur_ff        <= cur_in;
      hcur_ff       <= hcur_in;
      stat_ff       <= stat_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   // memories, registered reads
   always_ff @(posedge clock) begin
      if (smap_we) smap_mem[smap_waddr] <= smap_wdata;
      smap_rd_ff <= smap_mem[smap_raddr];
   end

   always_ff @(posedge clock) begin
      if (hmap_we) hmap_mem[hmap_waddr] <= hmap_wdata;
      hmap_rd_ff <= hmap_mem[hmap_raddr];
   end

   always_ff @(posedge clock) begin
      if (hstk_we) hstk_mem[hstk_waddr] <= hstk_wdata;
      hstk_rd_ff <= hstk_mem[hstk_raddr];
   end

   always_ff @(posedge clock) begin
      if (sstk_we) sstk_mem[sstk_waddr] <= sstk_wdata;
      sstk_rd_ff <= sstk_mem[sstk_raddr];
   end

endmodule

>>> tb/sv/two_size_page_allocator_unit_test.sv
`timescale 1ns / 1ps
// two_size_page_allocator_unit_test: self-checking bench for the two-size page allocator
// depends on tspa_pkg and two_size_page_allocator_unit

module two_size_page_allocator_unit_test;

   localparam int unsigned HUGE_CAP  = 64;
   localparam int unsigned SMALL_CAP = HUGE_CAP * 512;
   localparam int unsigned PHASE_ITEMS = 110;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = '0;
   logic [1:0]  req_page_kind = '0;
   logic [14:0] req_first_page = '0;
   logic [15:0] req_range_length = '0;
   logic [26:0] req_free_address = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [26:0] rsp_page_address;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = '0;

   two_size_page_allocator_unit #(.HUGE_PAGES(HUGE_CAP)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_page_kind(req_page_kind),
      .req_first_page(req_first_page), .req_range_length(req_range_length),
      .req_free_address(req_free_address),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_page_address(rsp_page_address),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always #6 clock = ~clock;

   // one expected result transfer
   typedef struct {
      logic [2:0]  status;
      logic [26:0] page_address;
   } alloc_result_type;

   // an address handed out by the allocator, kept so it can be given back later
   typedef struct {
      logic [1:0]  kind;
      logic [26:0] page_address;
   } held_page_type;

   // directed row; known_result marks rows whose answer is typed in
   typedef struct {
      logic [1:0]  op;
      logic [1:0]  kind;
      logic [14:0] first_page;
      logic [15:0] range_length;
      logic [26:0] free_address;
      bit          known_result;
      logic [2:0]  status;
      logic [26:0] page_address;
   } directed_row_type;

   alloc_result_type pending_results[$];
   held_page_type    held_pages[$];
   int               mismatch_count = 0;
   bit               steady_flow = 1'b0;   // no idling on either side while set

   // shadow copy of the allocator state
   int unsigned page_total = SMALL_CAP;
   bit          huge_used[HUGE_CAP];
   bit          small_used[SMALL_CAP];
   int unsigned huge_stack[HUGE_CAP];
   int unsigned huge_top = 0;
   int unsigned small_stack[SMALL_CAP];
   int unsigned small_top = 0;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic bit push_huge_page(input int unsigned idx);
      if (huge_top >= HUGE_CAP) return 1'b0;
      huge_stack[huge_top] = idx;
      huge_top++;
      return 1'b1;
   endfunction

   function automatic bit push_small_page(input int unsigned idx);
      if (small_top >= SMALL_CAP) return 1'b0;
      small_stack[small_top] = idx;
      small_top++;
      return 1'b1;
   endfunction

   function automatic bit huge_page_clean(input int unsigned idx);
      for (int j = 0; j < 512; j++)
         if (small_used[idx * 512 + j]) return 1'b0;
      return 1'b1;
   endfunction

   // works out the answer of one request and moves the shadow state along
   task automatic predict_allocation(input logic [1:0] op, input logic [1:0] kind,
                                     input logic [14:0] first_pg, input logic [15:0] len,
                                     input logic [26:0] address,
                                     output logic [2:0] status, output logic [26:0] pa);
      int unsigned limit, p, idx, huge_count;
      bit done;
      status = tspa_pkg::STAT_OK;
      pa = '0;
      huge_count = page_total / 512;
      if (op == tspa_pkg::OP_BUILD) begin
         for (int i = 0; i < huge_count; i++) begin
            if (huge_used[i]) continue;
            if (huge_page_clean(i)) begin
               if (!push_huge_page(i)) status = tspa_pkg::STAT_FULL;
            end else begin
               huge_used[i] = 1'b1;
            end
         end
         for (int i = 0; i < page_total; i++) begin
            if (small_used[i]) continue;
            if (!huge_used[i / 512]) begin
               if (!push_small_page(i)) status = tspa_pkg::STAT_FULL;
            end else begin
               small_used[i] = 1'b1;
            end
         end
      end else if (kind != tspa_pkg::KIND_SMALL && kind != tspa_pkg::KIND_HUGE) begin
         status = tspa_pkg::STAT_BAD_SIZE;
      end else if (op == tspa_pkg::OP_RESERVE) begin
         limit = (kind == tspa_pkg::KIND_SMALL) ? page_total : huge_count;
         for (int i = 0; i < len; i++) begin
            p = first_pg + i;
            if (p >= limit) begin
               status = tspa_pkg::STAT_RANGE;
            end else if (kind == tspa_pkg::KIND_SMALL) begin
               small_used[p] = 1'b1;
            end else begin
               huge_used[p] = 1'b1;
            end
         end
      end else if (op == tspa_pkg::OP_ALLOC) begin
         done = 1'b0;
         status = tspa_pkg::STAT_EMPTY;
         if (kind == tspa_pkg::KIND_HUGE) begin
            // stale entries are dropped until a clean huge page turns up
            while (huge_top > 0 && !done) begin
               huge_top--;
               idx = huge_stack[huge_top] % HUGE_CAP;
               if (!huge_page_clean(idx)) continue;
               huge_used[idx] = 1'b1;
               for (int j = 0; j < 512; j++) small_used[idx * 512 + j] = 1'b1;
               pa = 27'(idx * 32'h200000);
               status = tspa_pkg::STAT_OK;
               done = 1'b1;
            end
         end else begin
            // only the containing huge bit is checked here
            while (small_top > 0 && !done) begin
               small_top--;
               idx = small_stack[small_top] % SMALL_CAP;
               if (huge_used[idx / 512]) continue;
               small_used[idx] = 1'b1;
               pa = 27'(idx * 32'h1000);
               status = tspa_pkg::STAT_OK;
               done = 1'b1;
            end
         end
      end else if (kind == tspa_pkg::KIND_HUGE) begin
         idx = address / 32'h200000;
         if (idx >= huge_count) status = tspa_pkg::STAT_RANGE;
         else if (!huge_used[idx]) status = tspa_pkg::STAT_REJECT;
         else begin
            huge_used[idx] = 1'b0;
            for (int j = 0; j < 512; j++) small_used[idx * 512 + j] = 1'b0;
            if (!push_huge_page(idx)) status = tspa_pkg::STAT_FULL;
            for (int j = 0; j < 512; j++)
               if (!push_small_page(idx * 512 + j)) status = tspa_pkg::STAT_FULL;
         end
      end else begin
         idx = address / 32'h1000;
         if (idx >= page_total) status = tspa_pkg::STAT_RANGE;
         else if (!small_used[idx] || huge_used[idx / 512]) status = tspa_pkg::STAT_REJECT;
         else begin
            small_used[idx] = 1'b0;
            if (!push_small_page(idx)) status = tspa_pkg::STAT_FULL;
         end
      end
      if (status != tspa_pkg::STAT_OK) pa = '0;
   endtask

   // drives one request and waits for its transfer; the answer is queued on acceptance
   task automatic send_request(input logic [1:0] op, input logic [1:0] kind,
                               input logic [14:0] first_pg, input logic [15:0] len,
                               input logic [26:0] address, input bit known_result,
                               input logic [2:0] known_status, input logic [26:0] known_pa);
      int gap;
      alloc_result_type predicted;
      gap = steady_flow ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_operation    <= op;
      req_page_kind    <= kind;
      req_first_page   <= first_pg;
      req_range_length <= len;
      req_free_address <= address;
      req_valid        <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_allocation(op, kind, first_pg, len, address,
                         predicted.status, predicted.page_address);
      // remember handed-out pages so later frees form proper pairs
      if (op == tspa_pkg::OP_ALLOC && predicted.status == tspa_pkg::STAT_OK)
         held_pages.push_back('{kind, predicted.page_address});
      if (known_result) begin
         predicted.status = known_status;
         predicted.page_address = known_pa;
      end
      pending_results.push_back(predicted);
   endtask

   // drains the block so the size register can be changed safely
   task automatic wait_idle;
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_page_total(input logic [15:0] value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      // values above the capacity saturate
      page_total = (value > SMALL_CAP) ? SMALL_CAP : value;
   endtask

   // random traffic: mostly allocate/free pairs, plus reserves, builds and noise
   task automatic random_request;
      int unsigned   pick, sel, hc;
      logic [1:0]    kind;
      logic [14:0]   first_pg;
      logic [15:0]   len;
      logic [26:0]   address;
      held_page_type page;
      pick = $urandom_range(0, 99);
      hc = page_total / 512;
      kind = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(2, 3))
           : ($urandom_range(0, 3) == 0) ? tspa_pkg::KIND_HUGE : tspa_pkg::KIND_SMALL;
      first_pg = 15'($urandom);
      len = 16'($urandom_range(0, 8));
      address = 27'($urandom);
      if (pick < 33) begin
         send_request(tspa_pkg::OP_ALLOC, kind, first_pg, len, address, 1'b0, '0, '0);
      end else if (pick < 63 && held_pages.size() != 0) begin
         sel = $urandom_range(0, held_pages.size() - 1);
         page = held_pages[sel];
         held_pages.delete(sel);
         // occasionally give it back with the wrong size or twice
         if ($urandom_range(0, 9) == 0) page.kind = {1'b0, ~page.kind[0]};
         if ($urandom_range(0, 9) == 0) held_pages.push_back(page);
         send_request(tspa_pkg::OP_FREE, page.kind, first_pg, len, page.page_address,
                      1'b0, '0, '0);
      end else if (pick < 73) begin
         if ($urandom_range(0, 1) == 0 && page_total != 0)
            address = (kind == tspa_pkg::KIND_HUGE && hc != 0)
                    ? 27'($urandom_range(0, hc - 1) * 32'h200000)
                    : 27'($urandom_range(0, page_total - 1) * 32'h1000);
         send_request(tspa_pkg::OP_FREE, kind, first_pg, len, address, 1'b0, '0, '0);
      end else if (pick < 90) begin
         if ($urandom_range(0, 2) != 0)
            first_pg = 15'($urandom_range(0, (kind == tspa_pkg::KIND_HUGE) ? hc : page_total));
         // long ranges are slow, so they stay rare
         if ($urandom_range(0, 199) == 0) len = 16'($urandom);
         send_request(tspa_pkg::OP_RESERVE, kind, first_pg, len, address, 1'b0, '0, '0);
      end else if (pick < 96 && page_total <= 4096) begin
         send_request(tspa_pkg::OP_BUILD, 2'($urandom), first_pg, len, address,
                      1'b0, '0, '0);
      end else if (pick < 96) begin
         send_request(tspa_pkg::OP_ALLOC, tspa_pkg::KIND_SMALL, first_pg, len, address,
                      1'b0, '0, '0);
      end else begin
         // noise on every field, but never a full build at large sizes
         send_request((page_total <= 4096) ? 2'($urandom) : 2'($urandom_range(2, 3)),
                      2'($urandom), first_pg, len, address, 1'b0, '0, '0);
      end
   endtask

   // directed opening: empty stacks, bad sizes, ranges, then a full build and stack overflow
   directed_row_type opening_rows[] = '{
      '{tspa_pkg::OP_ALLOC,   tspa_pkg::KIND_SMALL, 15'd0,    16'd0, 27'd0,
        1'b1, tspa_pkg::STAT_EMPTY,    27'd0},
      '{tspa_pkg::OP_ALLOC,   tspa_pkg::KIND_HUGE,  15'd0,    16'd0, 27'd0,
        1'b1, tspa_pkg::STAT_EMPTY,    27'd0},
      '{tspa_pkg::OP_FREE,    tspa_pkg::KIND_SMALL, 15'd0,    16'd0, 27'd0,
        1'b1, tspa_pkg::STAT_REJECT,   27'd0},
      '{tspa_pkg::OP_FREE,    tspa_pkg::KIND_HUGE,  15'd0,    16'd0, 27'h7FFFFFF,
        1'b1, tspa_pkg::STAT_REJECT,   27'd0},
      '{tspa_pkg::OP_RESERVE, 2'd2,                 15'd5,    16'd1, 27'd0,
        1'b1, tspa_pkg::STAT_BAD_SIZE, 27'd0},
      '{tspa_pkg::OP_ALLOC,   2'd3,                 15'd0,    16'd0, 27'd0,
        1'b1, tspa_pkg::STAT_BAD_SIZE, 27'd0},
      '{tspa_pkg::OP_FREE,    2'd2,                 15'd0,    16'd0, 27'h1000,
        1'b1, tspa_pkg::STAT_BAD_SIZE, 27'd0},
      '{tspa_pkg::OP_RESERVE, tspa_pkg::KIND_SMALL, 15'h7FFF, 16'd2, 27'd0,
        1'b1, tspa_pkg::STAT_RANGE,    27'd0},
      '{tspa_pkg::OP_RESERVE, tspa_pkg::KIND_HUGE,  15'd63,   16'd1, 27'd0,
        1'b1, tspa_pkg::STAT_OK,       27'd0},
      '{tspa_pkg::OP_RESERVE, tspa_pkg::KIND_HUGE,  15'h7FFF, 16'd0, 27'd0,
        1'b1, tspa_pkg::STAT_OK,       27'd0},
      '{tspa_pkg::OP_RESERVE, tspa_pkg::KIND_HUGE,  15'd64,   16'd1, 27'd0,
        1'b1, tspa_pkg::STAT_RANGE,    27'd0},
      '{tspa_pkg::OP_RESERVE, tspa_pkg::KIND_SMALL, 15'd1000, 16'd3, 27'd0,
        1'b1, tspa_pkg::STAT_OK,       27'd0},
      '{tspa_pkg::OP_FREE,    tspa_pkg::KIND_SMALL, 15'd0,    16'd0, 27'h3E8000,
        1'b0, '0, '0},
      '{tspa_pkg::OP_BUILD,   2'd3,                 15'd0,    16'd0, 27'd0,
        1'b0, '0, '0},
      '{tspa_pkg::OP_BUILD,   2'd3,                 15'd0,    16'd0, 27'd0,
        1'b0, '0, '0},
      '{tspa_pkg::OP_ALLOC,   tspa_pkg::KIND_SMALL, 15'd0,    16'd0, 27'd0,
        1'b0, '0, '0},
      '{tspa_pkg::OP_FREE,    tspa_pkg::KIND_SMALL, 15'd0,    16'd0, 27'h3E9000,
        1'b0, '0, '0},
      '{tspa_pkg::OP_ALLOC,   tspa_pkg::KIND_HUGE,  15'd0,    16'd0, 27'd0,
        1'b0, '0, '0},
      '{tspa_pkg::OP_FREE,    tspa_pkg::KIND_HUGE,  15'd0,    16'd0, 27'h7C00000,
        1'b0, '0, '0},
      '{tspa_pkg::OP_ALLOC,   tspa_pkg::KIND_HUGE,  15'd0,    16'd0, 27'd0,
        1'b0, '0, '0},
      '{tspa_pkg::OP_FREE,    tspa_pkg::KIND_HUGE,  15'd0,    16'd0, 27'h7C00000,
        1'b0, '0, '0},
      '{tspa_pkg::OP_ALLOC,   tspa_pkg::KIND_HUGE,  15'd0,    16'd0, 27'd0,
        1'b0, '0, '0},
      '{tspa_pkg::OP_FREE,    tspa_pkg::KIND_HUGE,  15'd0,    16'd0, 27'h7C00000,
        1'b0, '0, '0}
   };

   // size settings walked by the random part: extremes, saturating values, odd sizes
   logic [15:0] size_settings[] = '{16'd1024, 16'd0, 16'hFFFF, 16'd512, 16'd1536,
                                    16'd40000, 16'd2048, 16'd700, 16'd32768};

   // result side: random stall after each transfer unless steady_flow is set, checked against the oldest expectation
   int stall_left = 0;
   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result status %0d", rsp_status));
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               if (rsp_page_address !== want.page_address)
                  report_mismatch($sformatf("page address %h, expected %h",
                                            rsp_page_address, want.page_address));
            end
            stall_left = steady_flow ? 0 : $urandom_range(0, 4);
         end
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // stimulus
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // the block clears its bitmaps first; the handshake covers that wait
      foreach (opening_rows[r])
         send_request(opening_rows[r].op, opening_rows[r].kind, opening_rows[r].first_page,
                      opening_rows[r].range_length, opening_rows[r].free_address,
                      opening_rows[r].known_result, opening_rows[r].status,
                      opening_rows[r].page_address);
      foreach (size_settings[s]) begin
         write_page_total(size_settings[s]);
         steady_flow = (s % 3 == 2);
         repeat (PHASE_ITEMS) random_request();
      end
      wait_idle();
      repeat (200) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // run limit, far above the slowest legal run including the clearing pass
   initial begin
      #(12 * 40000000);
      $display("== FAIL ==");
      $finish;
   end

endmodule

>>> filelist.f
rtl/tspa_pkg.sv
rtl/two_size_page_allocator_unit.sv
tb/sv/two_size_page_allocator_unit_test.sv
